>>> src/mfep_pkg.sv
// Shared types and constants of the MIDI file event parser.
// Holds the result record, the push bundle and the saturating tick adder.
// No dependencies.
`default_nettype none

package mfep_pkg;

  localparam int unsigned TickW = 48;
  localparam logic [TickW-1:0] TickMax = '1;

  // The queue depth and the pushes per byte set the room check in the queue.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = QPtrW + 1;
  localparam int unsigned MaxPush = 2;

  localparam logic [31:0] MagicHeader = 32'h4D54_6864;
  localparam logic [31:0] MagicTrack = 32'h4D54_726B;

  typedef enum logic [3:0] {
    KIND_NOTE_ON    = 4'd0,
    KIND_NOTE_OFF   = 4'd1,
    KIND_CONTROL    = 4'd2,
    KIND_PROGRAM    = 4'd3,
    KIND_META       = 4'd4,
    KIND_BAD_HEADER = 4'd5,
    KIND_BAD_TRACK  = 4'd6,
    KIND_TRUNCATED  = 4'd7,
    KIND_SUMMARY    = 4'd8
  } kind_e;

  typedef struct packed {
    kind_e            event_kind;
    logic [15:0]      track_number;
    logic [TickW-1:0] event_tick;
    logic [3:0]       midi_channel;
    logic [7:0]       first_data;
    logic [7:0]       second_data;
    logic [31:0]      note_on_total;
    logic [15:0]      channels_used;
    logic [TickW-1:0] all_tracks_ticks;
    logic             run_last;
  } result_t;

  // Up to two results per byte; r1 is only used together with r0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic [TickW-1:0] sat_add(logic [TickW-1:0] a, logic [31:0] d);
    logic [TickW:0] sum;
    sum = {1'b0, a} + {{(TickW + 1 - 32){1'b0}}, d};
    return sum[TickW] ? TickMax : sum[TickW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/mfep_parser.sv
// Parse state of the MIDI file event parser and its per-byte update.
// Consumes one registered byte per transfer and emits up to two results.
// Depends on mfep_pkg.
`default_nettype none

module mfep_parser
  import mfep_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       eof_i,
  output push_t           push_o
);

  typedef enum logic [15:0] {
    PH_HMAGIC = 16'h0001,
    PH_HLEN   = 16'h0002,
    PH_HFMT   = 16'h0004,
    PH_HNTRK  = 16'h0008,
    PH_HDIV   = 16'h0010,
    PH_TMAGIC = 16'h0020,
    PH_TLEN   = 16'h0040,
    PH_DELTA  = 16'h0080,
    PH_STATUS = 16'h0100,
    PH_DATA1  = 16'h0200,
    PH_DATA2  = 16'h0400,
    PH_MTYPE  = 16'h0800,
    PH_MLEN   = 16'h1000,
    PH_XLEN   = 16'h2000,
    PH_SKIP   = 16'h4000,
    PH_DONE   = 16'h8000
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [2:0]       idx;
    logic [31:0]      shf;
    logic [15:0]      texp;
    logic [15:0]      tdone;
    logic [31:0]      tleft;
    logic [7:0]       rs;
    logic [31:0]      lacc;
    logic [TickW-1:0] ttick;
    logic [7:0]       held;
    logic [31:0]      skip;
    logic [31:0]      noc;
    logic [15:0]      cmask;
    logic [TickW-1:0] tsum;
    logic             halt;
  } state_t;

  function automatic state_t reset_state();
    state_t s;
    s = '0;
    s.phase = PH_HMAGIC;
    return s;
  endfunction

  function automatic state_t end_track(state_t s_in);
    state_t s;
    s = s_in;
    if (s.tdone != 16'hFFFF) begin
      s.tdone = s.tdone + 16'd1;
    end
    s.idx = '0;
    s.shf = '0;
    s.phase = (s.tdone >= s.texp) ? PH_DONE : PH_TMAGIC;
    return s;
  endfunction

  function automatic result_t mk(kind_e k, state_t s, logic [TickW-1:0] tick,
                                 logic [3:0] ch, logic [7:0] d1, logic [7:0] d2);
    result_t r;
    r.event_kind = k;
    r.track_number = s.tdone;
    r.event_tick = tick;
    r.midi_channel = ch;
    r.first_data = d1;
    r.second_data = d2;
    r.note_on_total = s.noc;
    r.channels_used = s.cmask;
    r.all_tracks_ticks = s.tsum;
    r.run_last = 1'b0;
    return r;
  endfunction

  state_t      st_q, st_d;
  logic        pv;
  result_t     pr, er;
  kind_e       ek;
  logic [2:0]  flen;
  logic [31:0] fval;
  logic [3:0]  hi, ch;

  assign hi = st_q.rs[7:4];
  assign ch = st_q.rs[3:0];

  always_comb begin
    st_d = st_q;
    pv = 1'b0;
    pr = '0;
    er = '0;
    ek = KIND_SUMMARY;
    flen = 3'd4;
    fval = '0;
    push_o = '0;

    if (!st_q.halt) begin
      case (st_q.phase)
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_XLEN,
        PH_SKIP: begin
          if (st_q.tleft != 32'd0) begin
            st_d.tleft = st_q.tleft - 32'd1;
          end
          case (st_q.phase)
            PH_DELTA: begin
              st_d.lacc = {st_q.lacc[24:0], byte_i[6:0]};
              if (!byte_i[7]) begin
                st_d.ttick = sat_add(st_q.ttick, st_d.lacc);
                st_d.tsum = sat_add(st_q.tsum, st_d.lacc);
                st_d.lacc = '0;
                st_d.phase = PH_STATUS;
              end
            end
            PH_STATUS, PH_DATA1: begin
              if (st_q.phase == PH_STATUS && byte_i[7]) begin
                if (byte_i[7:4] == 4'hF) begin
                  // System and meta status bytes cancel running status.
                  st_d.rs = '0;
                  st_d.lacc = '0;
                  st_d.phase = (byte_i == 8'hFF) ? PH_MTYPE : PH_XLEN;
                end else begin
                  st_d.rs = byte_i;
                  st_d.phase = PH_DATA1;
                end
              end else if (st_q.phase == PH_STATUS && st_q.rs == 8'd0) begin
                // Data with no status to run on: give up on this track.
                st_d.skip = st_d.tleft;
                st_d.phase = PH_SKIP;
              end else if (hi == 4'hC) begin
                pv = 1'b1;
                pr = mk(KIND_PROGRAM, st_d, st_q.ttick, ch, byte_i, 8'd0);
                st_d.phase = PH_DELTA;
              end else if (hi == 4'hD) begin
                st_d.phase = PH_DELTA;
              end else begin
                st_d.held = byte_i;
                st_d.phase = PH_DATA2;
              end
            end
            PH_DATA2: begin
              if (hi == 4'h9) begin
                if (byte_i != 8'd0) begin
                  if (st_q.noc != 32'hFFFF_FFFF) begin
                    st_d.noc = st_q.noc + 32'd1;
                  end
                  st_d.cmask = st_q.cmask | (16'd1 << ch);
                end
                pv = 1'b1;
                pr = mk(KIND_NOTE_ON, st_d, st_q.ttick, ch, st_q.held, byte_i);
              end else if (hi == 4'h8) begin
                st_d.cmask = st_q.cmask | (16'd1 << ch);
                pv = 1'b1;
                pr = mk(KIND_NOTE_OFF, st_d, st_q.ttick, ch, st_q.held, byte_i);
              end else if (hi == 4'hB) begin
                pv = 1'b1;
                pr = mk(KIND_CONTROL, st_d, st_q.ttick, ch, st_q.held, byte_i);
              end
              st_d.phase = PH_DELTA;
            end
            PH_MTYPE: begin
              st_d.held = byte_i;
              st_d.lacc = '0;
              st_d.phase = PH_MLEN;
            end
            PH_MLEN, PH_XLEN: begin
              st_d.lacc = {st_q.lacc[24:0], byte_i[6:0]};
              if (!byte_i[7]) begin
                if (st_q.phase == PH_MLEN) begin
                  pv = 1'b1;
                  pr = mk(KIND_META, st_d, st_q.ttick, 4'd0, st_q.held, 8'd0);
                end
                st_d.skip = st_d.lacc;
                st_d.lacc = '0;
                st_d.phase = (st_d.skip == 32'd0) ? PH_DELTA : PH_SKIP;
              end
            end
            default: begin
              if (st_q.skip != 32'd0) begin
                st_d.skip = st_q.skip - 32'd1;
              end
              if (st_d.skip == 32'd0) begin
                st_d.phase = PH_DELTA;
              end
            end
          endcase
          // Whatever is still open when the track length runs out is dropped.
          if (st_d.tleft == 32'd0) begin
            st_d = end_track(st_d);
          end
        end
        PH_HMAGIC, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_TMAGIC, PH_TLEN: begin
          if (st_q.phase == PH_HFMT || st_q.phase == PH_HNTRK || st_q.phase == PH_HDIV) begin
            flen = 3'd2;
          end
          st_d.shf = {st_q.shf[23:0], byte_i};
          st_d.idx = st_q.idx + 3'd1;
          if (st_d.idx >= flen) begin
            fval = st_d.shf;
            st_d.idx = '0;
            st_d.shf = '0;
            case (st_q.phase)
              PH_HMAGIC: begin
                if (fval != MagicHeader) begin
                  pv = 1'b1;
                  pr = mk(KIND_BAD_HEADER, st_d, '0, 4'd0, 8'd0, 8'd0);
                  st_d.halt = 1'b1;
                end else begin
                  st_d.phase = PH_HLEN;
                end
              end
              PH_HLEN: st_d.phase = PH_HFMT;
              PH_HFMT: st_d.phase = PH_HNTRK;
              PH_HNTRK: begin
                st_d.texp = fval[15:0];
                st_d.phase = PH_HDIV;
              end
              PH_HDIV: st_d.phase = (st_q.texp == 16'd0) ? PH_DONE : PH_TMAGIC;
              PH_TMAGIC: begin
                if (fval != MagicTrack) begin
                  pv = 1'b1;
                  pr = mk(KIND_BAD_TRACK, st_d, '0, 4'd0, 8'd0, 8'd0);
                  st_d.halt = 1'b1;
                end else begin
                  st_d.phase = PH_TLEN;
                end
              end
              default: begin
                st_d.tleft = fval;
                st_d.rs = '0;
                st_d.ttick = '0;
                st_d.lacc = '0;
                st_d.skip = '0;
                st_d.phase = PH_DELTA;
                if (fval == 32'd0) begin
                  st_d = end_track(st_d);
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    if (eof_i) begin
      ek = (!st_d.halt && st_d.phase != PH_DONE) ? KIND_TRUNCATED : KIND_SUMMARY;
      er = mk(ek, st_d, '0, 4'd0, 8'd0, 8'd0);
      er.run_last = 1'b1;
      push_o.v0 = 1'b1;
      if (pv) begin
        push_o.v1 = 1'b1;
        push_o.r0 = pr;
        push_o.r1 = er;
      end else begin
        push_o.r0 = er;
      end
      st_d = reset_state();
    end else begin
      pr.run_last = 1'b1;
      push_o.v0 = pv;
      push_o.r0 = pr;
    end

    if (!fire_i) begin
      push_o.v0 = 1'b0;
      push_o.v1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= reset_state();
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mfep_out_queue.sv
// Result queue of the MIDI file event parser.
// Takes up to two results per cycle and hands out one per transfer.
// Depends on mfep_pkg.
`default_nettype none

module mfep_out_queue
  import mfep_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output result_t    head_o
);

  result_t            mem_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [QCntW-1:0]   count_q, count_d;
  logic [QCntW-1:0]   n_push;
  logic               pop;

  // Room for a full push, so a byte is never taken without space for its results.
  assign room_o = count_q <= QCntW'(QueueDepth - MaxPush);
  assign out_valid_o = count_q != '0;
  assign head_o = mem_q[rptr_q];
  assign pop = out_valid_o && !out_stall_i;

  assign n_push = QCntW'(push_i.v0) + QCntW'(push_i.v1);
  assign wptr_nx = wptr_q + QPtrW'(1);
  assign wptr_d = wptr_q + n_push[QPtrW-1:0];
  assign rptr_d = pop ? rptr_q + QPtrW'(1) : rptr_q;
  assign count_d = count_q + n_push - QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("result queue count exceeds its depth");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v1 |-> push_i.v0)
    else $error("second result pushed without the first");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> $past(room_o) || count_q <= QCntW'(QueueDepth - MaxPush))
    else $error("result pushed into a queue without room");
`endif

endmodule

`default_nettype wire

>>> src/midi_file_event_parser.sv
// Top level of the MIDI file event parser: input register, parser, result queue.
// Depends on mfep_pkg, mfep_parser and mfep_out_queue.
//
// Usage: the file streams in one byte per input transfer on in_valid_i /
// in_stall_o, with end_of_file_i set on its last byte. Each byte yields zero,
// one or two results on out_valid_o / out_stall_i: note on and off, control
// and program changes, meta types, a bad header or track flag, and on the
// last byte a closing summary (or truncation flag). run_last_o marks the last
// result of a byte. After the closing result the parser starts over on a
// new file.
// Flow: a byte taken is held in the input register and parsed from there
// into the result queue; its results are offered from the queue head.
// Throughput is one byte per cycle while the queue has room; the limit is
// the four-entry result queue, which must have room for two results before a
// byte is parsed, so a stalled receiver backs up into in_stall_o and no
// result is lost. Reset clears the parse state and empties the queue; the
// block is ready at once after reset.
`default_nettype none

module midi_file_event_parser
  import mfep_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       event_kind_o,
  output logic [15:0]      track_number_o,
  output logic [47:0]      event_tick_o,
  output logic [3:0]       midi_channel_o,
  output logic [7:0]       first_data_o,
  output logic [7:0]       second_data_o,
  output logic [31:0]      note_on_total_o,
  output logic [15:0]      channels_used_o,
  output logic [47:0]      all_tracks_ticks_o,
  output logic             run_last_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eof_q;
  logic       room;
  logic       fire;
  push_t      push;
  result_t    head;

  assign fire = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= file_byte_i;
      eof_q <= end_of_file_i;
    end
  end

  mfep_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .eof_i  (eof_q),
    .push_o (push)
  );

  mfep_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign event_kind_o = head.event_kind;
  assign track_number_o = head.track_number;
  assign event_tick_o = head.event_tick;
  assign midi_channel_o = head.midi_channel;
  assign first_data_o = head.first_data;
  assign second_data_o = head.second_data;
  assign note_on_total_o = head.note_on_total;
  assign channels_used_o = head.channels_used;
  assign all_tracks_ticks_o = head.all_tracks_ticks;
  assign run_last_o = head.run_last;

endmodule

`default_nettype wire

>>> dv/tb_midi_file_event_parser.sv
// Testbench of the MIDI file event parser: streams generated MIDI files through the block
// and checks every result against a byte-level parser model kept in this file.
// Depends on mfep_pkg and midi_file_event_parser.

module tb_midi_file_event_parser;
  import mfep_pkg::*;

  localparam int HoldCycles = 80;
  localparam int IdlePct = 11;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 20;

  // High nibbles of channel status bytes and the system status bytes.
  localparam logic [3:0] StNoteOff = 4'h8;
  localparam logic [3:0] StNoteOn = 4'h9;
  localparam logic [3:0] StAftertouch = 4'hA;
  localparam logic [3:0] StControl = 4'hB;
  localparam logic [3:0] StProgram = 4'hC;
  localparam logic [3:0] StPressure = 4'hD;
  localparam logic [3:0] StPitchBend = 4'hE;
  localparam logic [7:0] SystemBase = 8'hF0;
  localparam logic [7:0] SysexStatus = 8'hF0;
  localparam logic [7:0] SysexEscape = 8'hF7;
  localparam logic [7:0] MetaStatus = 8'hFF;
  localparam logic [7:0] MetaEndTrack = 8'h2F;

  typedef enum logic [3:0] {
    HDR_MAGIC, HDR_LEN, HDR_FMT, HDR_NTRK, HDR_DIV, TRK_MAGIC, TRK_LEN,
    EV_DELTA, EV_STATUS, EV_DATA1, EV_DATA2, META_CODE, META_LEN, SYSEX_LEN,
    EV_SKIP, FILE_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } file_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  file_byte = 8'h00;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  event_kind;
  logic [15:0] track_number;
  logic [47:0] event_tick;
  logic [3:0]  midi_channel;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [31:0] note_on_total;
  logic [15:0] channels_used;
  logic [47:0] all_tracks_ticks;
  logic        run_last;

  midi_file_event_parser DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .file_byte_i       (file_byte),
    .end_of_file_i     (end_of_file),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .event_kind_o      (event_kind),
    .track_number_o    (track_number),
    .event_tick_o      (event_tick),
    .midi_channel_o    (midi_channel),
    .first_data_o      (first_data),
    .second_data_o     (second_data),
    .note_on_total_o   (note_on_total),
    .channels_used_o   (channels_used),
    .all_tracks_ticks_o(all_tracks_ticks),
    .run_last_o        (run_last)
  );

  always #1 clk = ~clk;

  // Parser model state.
  phase_e      ph;
  logic [2:0]  fld_count;
  logic [31:0] fld_value;
  logic [15:0] tracks_wanted;
  logic [15:0] tracks_seen;
  logic [31:0] bytes_left;
  logic [7:0]  run_status;
  logic [31:0] vlq_value;
  logic [47:0] trk_tick;
  logic [7:0]  held_byte;
  logic [31:0] skip_left;
  logic [31:0] note_on_tally;
  logic [15:0] chan_mask;
  logic [47:0] tick_total;
  logic        halted;

  result_t     byte_results[$];
  result_t     want_results[$];

  file_item_t  byte_stream[$];
  logic [7:0]  file_buf[$];
  logic [7:0]  trk_buf[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        byte_taken = 1'b0;
  logic        quiet = 1'b0;
  logic        hold_request = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  function automatic logic [47:0] tick_add(logic [47:0] a, logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, d};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  function automatic void clear_parser();
    ph = HDR_MAGIC;
    fld_count = '0;
    fld_value = '0;
    tracks_wanted = '0;
    tracks_seen = '0;
    bytes_left = '0;
    run_status = '0;
    vlq_value = '0;
    trk_tick = '0;
    held_byte = '0;
    skip_left = '0;
    note_on_tally = '0;
    chan_mask = '0;
    tick_total = '0;
    halted = 1'b0;
  endfunction

  function automatic void push_result(kind_e kind, logic [47:0] tick, logic [3:0] ch,
                                      logic [7:0] d1, logic [7:0] d2);
    result_t r;
    r.event_kind = kind;
    r.track_number = tracks_seen;
    r.event_tick = tick;
    r.midi_channel = ch;
    r.first_data = d1;
    r.second_data = d2;
    r.note_on_total = note_on_tally;
    r.channels_used = chan_mask;
    r.all_tracks_ticks = tick_total;
    r.run_last = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void close_track();
    if (tracks_seen != 16'hFFFF) tracks_seen++;
    fld_count = '0;
    fld_value = '0;
    ph = (tracks_seen >= tracks_wanted) ? FILE_DONE : TRK_MAGIC;
  endfunction

  // Shifts one byte into a variable-length quantity; true on its last byte.
  function automatic logic vlq_step(logic [7:0] b);
    vlq_value = {vlq_value[24:0], b[6:0]};
    return !b[7];
  endfunction

  function automatic void first_data_byte(logic [7:0] b);
    case (run_status[7:4])
      StProgram: begin
        push_result(KIND_PROGRAM, trk_tick, run_status[3:0], b, 8'h00);
        ph = EV_DELTA;
      end
      StPressure: ph = EV_DELTA;
      default: begin
        held_byte = b;
        ph = EV_DATA2;
      end
    endcase
  endfunction

  function automatic void track_event_byte(logic [7:0] b);
    logic [3:0] hi;
    logic [3:0] ch;
    hi = run_status[7:4];
    ch = run_status[3:0];
    if (bytes_left != 0) bytes_left--;
    case (ph)
      EV_DELTA: begin
        if (vlq_step(b)) begin
          trk_tick = tick_add(trk_tick, vlq_value);
          tick_total = tick_add(tick_total, vlq_value);
          vlq_value = '0;
          ph = EV_STATUS;
        end
      end
      EV_STATUS: begin
        if (b[7]) begin
          if (b >= SystemBase) begin
            run_status = '0;
            vlq_value = '0;
            ph = (b == MetaStatus) ? META_CODE : SYSEX_LEN;
          end else begin
            run_status = b;
            ph = EV_DATA1;
          end
        end else if (run_status == 8'h00) begin
          // Stray data with no status: the rest of the track is thrown away.
          skip_left = bytes_left;
          ph = EV_SKIP;
        end else begin
          first_data_byte(b);
        end
      end
      EV_DATA1: first_data_byte(b);
      EV_DATA2: begin
        if (hi == StNoteOn) begin
          if (b != 8'h00) begin
            if (note_on_tally != 32'hFFFF_FFFF) note_on_tally++;
            chan_mask[ch] = 1'b1;
          end
          push_result(KIND_NOTE_ON, trk_tick, ch, held_byte, b);
        end else if (hi == StNoteOff) begin
          chan_mask[ch] = 1'b1;
          push_result(KIND_NOTE_OFF, trk_tick, ch, held_byte, b);
        end else if (hi == StControl) begin
          push_result(KIND_CONTROL, trk_tick, ch, held_byte, b);
        end
        ph = EV_DELTA;
      end
      META_CODE: begin
        held_byte = b;
        vlq_value = '0;
        ph = META_LEN;
      end
      META_LEN, SYSEX_LEN: begin
        if (vlq_step(b)) begin
          if (ph == META_LEN) push_result(KIND_META, trk_tick, 4'h0, held_byte, 8'h00);
          skip_left = vlq_value;
          vlq_value = '0;
          ph = (skip_left == 0) ? EV_DELTA : EV_SKIP;
        end
      end
      default: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) ph = EV_DELTA;
      end
    endcase
    if (bytes_left == 0) close_track();
  endfunction

  function automatic void fixed_field_byte(logic [7:0] b);
    logic [31:0] v;
    int unsigned need;
    need = (ph >= HDR_FMT && ph <= HDR_DIV) ? 2 : 4;
    fld_value = {fld_value[23:0], b};
    fld_count = fld_count + 3'd1;
    if (fld_count >= need) begin
      v = fld_value;
      fld_count = '0;
      fld_value = '0;
      case (ph)
        HDR_MAGIC: begin
          if (v != MagicHeader) begin
            push_result(KIND_BAD_HEADER, '0, '0, '0, '0);
            halted = 1'b1;
          end else begin
            ph = HDR_LEN;
          end
        end
        HDR_LEN: ph = HDR_FMT;
        HDR_FMT: ph = HDR_NTRK;
        HDR_NTRK: begin
          tracks_wanted = v[15:0];
          ph = HDR_DIV;
        end
        HDR_DIV: ph = (tracks_wanted == 0) ? FILE_DONE : TRK_MAGIC;
        TRK_MAGIC: begin
          if (v != MagicTrack) begin
            push_result(KIND_BAD_TRACK, '0, '0, '0, '0);
            halted = 1'b1;
          end else begin
            ph = TRK_LEN;
          end
        end
        default: begin
          bytes_left = v;
          run_status = '0;
          trk_tick = '0;
          vlq_value = '0;
          skip_left = '0;
          ph = EV_DELTA;
          if (bytes_left == 0) close_track();
        end
      endcase
    end
  endfunction

  function automatic void parse_file_byte(logic [7:0] b, logic eof);
    result_t r;
    kind_e closing;
    byte_results.delete();
    if (!halted) begin
      if (ph >= EV_DELTA && ph <= EV_SKIP) track_event_byte(b);
      else if (ph != FILE_DONE) fixed_field_byte(b);
    end
    if (eof) begin
      if (!halted && ph != FILE_DONE) closing = KIND_TRUNCATED;
      else closing = KIND_SUMMARY;
      push_result(closing, '0, '0, '0, '0);
      clear_parser();
    end
    if (byte_results.size() != 0) begin
      r = byte_results.pop_back();
      r.run_last = 1'b1;
      byte_results.insert(byte_results.size(), r);
    end
    foreach (byte_results[i]) want_results.insert(want_results.size(), byte_results[i]);
  endfunction

  // File generation.
  function automatic void file_word(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) file_buf.insert(file_buf.size(), v[8*i +: 8]);
  endfunction

  // Encodes v as a variable-length quantity, with optional redundant leading bytes.
  function automatic void trk_vlq(logic [31:0] v, int pad);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    for (int i = 0; i < pad; i++) trk_buf.insert(trk_buf.size(), 8'h80);
    for (int i = n - 1; i >= 0; i--)
      trk_buf.insert(trk_buf.size(), {i != 0, 7'(v >> (7 * i))});
  endfunction

  function automatic logic [7:0] data_value();
    if ($urandom_range(99) < 3) return 8'($urandom);
    return 8'($urandom_range(127));
  endfunction

  function automatic void build_track();
    logic [7:0] status;
    logic [7:0] st;
    int pick;
    int len;
    trk_buf.delete();
    status = 8'h00;
    repeat ($urandom_range(8)) begin
      pick = $urandom_range(99);
      if (pick < 60) trk_vlq($urandom_range(127), 0);
      else if (pick < 92) trk_vlq($urandom_range(20000), $urandom_range(1));
      else trk_vlq($urandom, $urandom_range(1));
      pick = $urandom_range(99);
      st = {4'h0, 4'($urandom)};
      if (pick < 70) begin
        if (pick < 30) st[7:4] = StNoteOn;
        else if (pick < 42) st[7:4] = StNoteOff;
        else if (pick < 54) st[7:4] = StControl;
        else if (pick < 61) st[7:4] = StProgram;
        else if (pick < 64) st[7:4] = StPressure;
        else if (pick < 67) st[7:4] = StAftertouch;
        else st[7:4] = StPitchBend;
        // Running status: the status byte may be left out when it repeats.
        if (st != status || $urandom_range(1) == 0) trk_buf.insert(trk_buf.size(), st);
        status = st;
        trk_buf.insert(trk_buf.size(), data_value());
        if (st[7:4] == StNoteOn && $urandom_range(4) == 0)
          trk_buf.insert(trk_buf.size(), 8'h00);
        else if (st[7:4] != StProgram && st[7:4] != StPressure)
          trk_buf.insert(trk_buf.size(), data_value());
      end else if (pick < 95) begin
        status = 8'h00;
        if (pick < 85) begin
          trk_buf.insert(trk_buf.size(), MetaStatus);
          trk_buf.insert(trk_buf.size(), data_value());
        end else begin
          trk_buf.insert(trk_buf.size(), $urandom_range(1) ? SysexStatus : SysexEscape);
        end
        // A long payload runs past the track end and gets clamped there.
        len = ($urandom_range(19) == 0) ? $urandom_range(100, 300) : $urandom_range(4);
        trk_vlq(len, ($urandom_range(9) == 0) ? 1 : 0);
        repeat ((len < 6) ? len : 6) trk_buf.insert(trk_buf.size(), 8'($urandom));
      end else if (status == 8'h00) begin
        trk_buf.insert(trk_buf.size(), 8'($urandom_range(127)));
      end else begin
        st[7:4] = StControl;
        trk_buf.insert(trk_buf.size(), st);
        trk_buf.insert(trk_buf.size(), data_value());
        trk_buf.insert(trk_buf.size(), data_value());
        status = st;
      end
    end
    if ($urandom_range(1)) begin
      trk_buf.insert(trk_buf.size(), 8'h00);
      trk_buf.insert(trk_buf.size(), MetaStatus);
      trk_buf.insert(trk_buf.size(), MetaEndTrack);
      trk_buf.insert(trk_buf.size(), 8'h00);
    end
  endfunction

  function automatic void build_file();
    logic [31:0] magic;
    logic [31:0] len;
    logic [15:0] ntrk;
    int pick;
    int keep;
    file_buf.delete();
    if ($urandom_range(99) < 4) begin
      repeat ($urandom_range(1, 12)) file_buf.insert(file_buf.size(), 8'($urandom));
    end else begin
      magic = MagicHeader;
      if ($urandom_range(99) < 3) magic ^= 32'd1 << $urandom_range(31);
      file_word(magic, 4);
      file_word(($urandom_range(9) == 0) ? $urandom : 32'd6, 4);
      file_word($urandom_range(2), 2);
      ntrk = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      file_word(ntrk, 2);
      file_word($urandom, 2);
      for (int t = 0; t < ntrk && t < 4; t++) begin
        magic = MagicTrack;
        if ($urandom_range(99) < 3) magic ^= 32'd1 << $urandom_range(31);
        file_word(magic, 4);
        build_track();
        pick = $urandom_range(99);
        len = trk_buf.size();
        if (pick < 8 && len > 0) len = len - $urandom_range(1, (len < 3) ? len : 3);
        else if (pick < 15) len = len + $urandom_range(1, 3);
        else if (pick < 19) len = 0;
        else if (pick < 20) len = $urandom;
        file_word(len, 4);
        foreach (trk_buf[i]) file_buf.insert(file_buf.size(), trk_buf[i]);
      end
      if ($urandom_range(11) == 0)
        repeat ($urandom_range(1, 3)) file_buf.insert(file_buf.size(), 8'($urandom));
      if ($urandom_range(13) == 0) begin
        keep = $urandom_range(1, file_buf.size());
        while (file_buf.size() > keep) file_buf.delete(file_buf.size() - 1);
      end
    end
  endfunction

  function automatic void queue_file();
    file_item_t it;
    foreach (file_buf[i]) begin
      it.value = file_buf[i];
      it.last = (i == file_buf.size() - 1);
      byte_stream.insert(byte_stream.size(), it);
      queued_total++;
    end
  endfunction

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic wait_drained();
    while (accepted_total != queued_total || want_results.size() != 0) @(negedge clk);
  endtask

  // Sender: a new byte is offered only once the previous one has been taken.
  always @(negedge clk) begin : send_bytes
    file_item_t cur;
    if (rst_n && (!in_valid || byte_taken)) begin
      if (byte_stream.size() != 0 && (quiet || $urandom_range(99) >= IdlePct)) begin
        cur = byte_stream.pop_front();
        in_valid <= 1'b1;
        file_byte <= cur.value;
        end_of_file <= cur.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    byte_taken = rst_n && in_valid && !in_stall;
    if (byte_taken) begin
      parse_file_byte(file_byte, end_of_file);
      accepted_total++;
    end
  end

  // Receiver stall, with one long hold-off so the result queue backs up.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (want_results.size() == 0) begin
        $display("%0t: result of kind %0d arrived, expected none", $time, event_kind);
        mismatches++;
      end else begin
        want = want_results.pop_front();
        check_field("event_kind", want.event_kind, event_kind);
        check_field("track_number", want.track_number, track_number);
        check_field("event_tick", want.event_tick, event_tick);
        check_field("midi_channel", want.midi_channel, midi_channel);
        check_field("first_data", want.first_data, first_data);
        check_field("second_data", want.second_data, second_data);
        check_field("note_on_total", want.note_on_total, note_on_total);
        check_field("channels_used", want.channels_used, channels_used);
        check_field("all_tracks_ticks", want.all_tracks_ticks, all_tracks_ticks);
        check_field("run_last", want.run_last, run_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Bad header magic with the end of file on its last byte, a file of one
    // byte, and a header that declares no tracks at all.
    file_buf.delete();
    file_word(MagicHeader ^ 32'd1, 4);
    queue_file();
    file_buf.delete();
    file_buf.insert(file_buf.size(), 8'hFF);
    queue_file();
    file_buf.delete();
    file_word(MagicHeader, 4);
    file_word(32'd6, 4);
    file_word(32'd0, 2);
    file_word(32'd0, 2);
    file_word(32'h01E0, 2);
    queue_file();
    wait_drained();

    quiet = 1'b1;
    while (queued_total < 400) begin
      build_file();
      queue_file();
    end
    wait_drained();

    quiet = 1'b0;
    while (queued_total < 1120) begin
      build_file();
      queue_file();
    end
    while (accepted_total < 600) @(negedge clk);
    hold_request = 1'b1;
    wait_drained();
    repeat (DrainCycles) @(negedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
